// File: design/frame_grid_motion_detector_macros.svh
// Assertion macros for the frame grid motion detector.
`ifndef FRAME_GRID_MOTION_DETECTOR_MACROS_SVH
`define FRAME_GRID_MOTION_DETECTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FGMD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FGMD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define FGMD_ASSERT_IMPL(label, clk, rst_n, prop)
`define FGMD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: design/fgmd_pkg.sv
// Shared constants and the gray conversion for the frame grid motion detector.
package fgmd_pkg;
    localparam int GRID_COLS_DEF     = 32;
    localparam int GRID_ROWS_DEF     = 24;
    localparam int MAX_FRAME_DIM_DEF = 256;
    localparam int COUNT_MAX         = 127;

    localparam logic [2:0] REG_SENS   = 3'd0;
    localparam logic [2:0] REG_COOL   = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_THRESH = 3'd4;

    // gray from 8-bit expanded channels
    function automatic logic [7:0] gray_of(input logic [15:0] px);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [15:0] s;
        logic [31:0] q;
        begin
            r = {px[15:11], 3'b000};
            g = {px[10:5], 2'b00};
            b = {px[4:0], 3'b000};
            s = 16'(r * 30) + 16'(g * 59) + 16'(b * 11);
            // divide by 100: multiply by reciprocal, then correct
            q = (32'(s) * 32'd5243) >> 19;
            if (16'(q) * 16'd100 > s) q = q - 32'd1;
            gray_of = q[7:0];
        end
    endfunction
endpackage

// File: design/fgmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fgmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: design/fgmd_div.sv
// Restoring divider: 15-bit sum by 7-bit count, one quotient bit a cycle.
module fgmd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [14:0] i_num,
    input  logic [6:0]  i_den,
    output logic        o_done,
    output logic [7:0]  o_quot
);
    logic [14:0] r_q;
    logic [7:0]  r_rem;
    logic [6:0]  r_den;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [7:0]  w_trial;
    logic [7:0]  w_sub;

    assign w_trial = {r_rem[6:0], r_q[14]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd14) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= 8'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_sub;
                r_q   <= {r_q[13:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[13:0], 1'b0};
            end
        end
    end

    // average never exceeds 255, a zero count yields zero
    assign o_done = r_done;
    assign o_quot = (r_den == 7'd0) ? 8'd0 : r_q[7:0];
endmodule

// File: design/frame_grid_motion_detector.sv
// Top level of the frame grid motion detector.
// Usage: pixels enter on i_valid/o_stall in raster order, one item holds a
// RGB565 pixel, a last-pixel flag and a millisecond timestamp. Ordinary
// pixels each pass through a read of the cell accumulator memory, then
// its write-back. The last pixel of a frame starts an evaluation pass over
// every grid cell; each cell reads its accumulator and previous average,
// runs the serial divider and writes back the new average and a cleared
// accumulator. One result item then leaves on o_valid/i_stall; it waits in
// the output register while the receiver stalls, and no new pixel is
// taken until it is delivered.
// After reset a clearing pass writes zero to every cell of both memories,
// one cell a cycle (768 cells by default); pixels are held off meanwhile
// while configuration writes are taken as ever. Registers reset to their
// documented defaults.
`include "frame_grid_motion_detector_macros.svh"
module frame_grid_motion_detector #(
    parameter int GRID_COLS     = fgmd_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS     = fgmd_pkg::GRID_ROWS_DEF,
    parameter int MAX_FRAME_DIM = fgmd_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_pixel_rgb565,
    input  logic        i_last_pixel,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_motion_event,
    output logic [9:0]  o_changed_cells,
    output logic        o_priming_frame,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int PW    = $clog2(MAX_FRAME_DIM + 1);
    localparam int GXW   = $clog2(GRID_COLS);
    localparam int GYW   = $clog2(GRID_ROWS);
    localparam int MW    = PW + 7;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_ERD   = 3'd3;
    localparam logic [2:0] S_EDIV  = 3'd4;
    localparam logic [2:0] S_EWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state;
    logic [6:0]  r_sens;
    logic [31:0] r_cool;
    logic [8:0]  r_fw;
    logic [8:0]  r_fh;
    logic [7:0]  r_thr;
    logic [PW-1:0] r_col;
    logic [PW-1:0] r_row;
    logic        r_primed;
    logic [31:0] r_cend;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_changed;
    logic [7:0]  r_gray;
    logic        r_last;
    logic [31:0] r_now;
    logic        r_o_valid;
    logic        r_motion;
    logic [9:0]  r_ocnt;
    logic        r_prime_o;

    logic [PW-1:0] w_w;
    logic [PW-1:0] w_h;
    logic [MW-1:0] w_gx;
    logic [MW-1:0] w_gy;
    logic [GXW-1:0] w_cx;
    logic [GYW-1:0] w_cy;
    logic [AW-1:0] w_idx;
    logic        w_acc_take;
    logic [21:0] w_acc_rd;
    logic [7:0]  w_prev_rd;
    logic        w_acc_we;
    logic [21:0] w_acc_wd;
    logic        w_prev_we;
    logic [7:0]  w_prev_wd;
    logic [AW-1:0] w_raddr;
    logic        w_div_done;
    logic [7:0]  w_avg;
    logic [7:0]  w_diff;
    logic [6:0]  w_s;
    logic [31:0] w_need;
    logic [CW-1:0] w_chg_n;

    always_comb begin
        w_w = (r_fw < 9'(GRID_COLS)) ? PW'(GRID_COLS)
            : ((32'(r_fw) > 32'(MAX_FRAME_DIM)) ? PW'(MAX_FRAME_DIM) : PW'(r_fw));
        w_h = (r_fh < 9'(GRID_ROWS)) ? PW'(GRID_ROWS)
            : ((32'(r_fh) > 32'(MAX_FRAME_DIM)) ? PW'(MAX_FRAME_DIM) : PW'(r_fh));
    end

    // cell column and row by a short search over the cell bounds
    always_comb begin
        w_gx = '0;
        w_gy = '0;
        for (int k = 1; k < GRID_COLS; k++)
            if (MW'(r_col) * MW'(GRID_COLS) >= MW'(k) * MW'(w_w))
                w_gx = MW'(k);
        for (int k = 1; k < GRID_ROWS; k++)
            if (MW'(r_row) * MW'(GRID_ROWS) >= MW'(k) * MW'(w_h))
                w_gy = MW'(k);
        w_cx  = GXW'(w_gx);
        w_cy  = GYW'(w_gy);
        w_idx = AW'(32'(w_cy) * GRID_COLS + 32'(w_cx));
    end

    assign w_acc_take = (r_state == S_IDLE) && i_valid;
    assign o_stall    = (r_state != S_IDLE);
    assign w_raddr    = (r_state == S_IDLE) ? w_idx : r_addr;

    // accumulator memory: sum in bits 21..7, count in 6..0
    always_comb begin
        w_acc_we = 1'b0;
        w_acc_wd = '0;
        w_prev_we = 1'b0;
        w_prev_wd = w_avg;
        unique case (r_state)
            S_CLEAR: begin
                w_acc_we  = 1'b1;
                w_prev_we = 1'b1;
                w_prev_wd = 8'd0;
            end
            S_ACC: begin
                w_acc_we = (w_acc_rd[6:0] < 7'(fgmd_pkg::COUNT_MAX));
                w_acc_wd = {w_acc_rd[21:7] + 15'(r_gray), w_acc_rd[6:0] + 7'd1};
            end
            S_EWAIT: begin
                w_acc_we  = w_div_done;
                w_prev_we = w_div_done;
            end
            default: ;
        endcase
    end

    fgmd_ram #(.WIDTH(22), .DEPTH(CELLS)) u_acc (
        .i_clk(i_clk), .i_we(w_acc_we), .i_waddr(r_addr), .i_wdata(w_acc_wd),
        .i_raddr(w_raddr), .o_rdata(w_acc_rd)
    );
    fgmd_ram #(.WIDTH(8), .DEPTH(CELLS)) u_prev (
        .i_clk(i_clk), .i_we(w_prev_we), .i_waddr(r_addr), .i_wdata(w_prev_wd),
        .i_raddr(w_raddr), .o_rdata(w_prev_rd)
    );

    fgmd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == S_EDIV),
        .i_num(w_acc_rd[21:7]), .i_den(w_acc_rd[6:0]),
        .o_done(w_div_done), .o_quot(w_avg)
    );

    assign w_diff  = (w_avg > w_prev_rd) ? w_avg - w_prev_rd : w_prev_rd - w_avg;
    assign w_chg_n = r_changed + CW'(w_diff > r_thr);

    // needed count per sensitivity step, each entry folded to a constant
    always_comb begin
        w_s = (r_sens < 7'd1) ? 7'd1 : ((r_sens > 7'd100) ? 7'd100 : r_sens);
        w_need = 32'd2;
        for (int k = 1; k <= 100; k++)
            if (w_s == 7'(k))
                w_need = 32'((CELLS * (22968 - 220 * (k - 1))) / 99000);
        if (w_need < 32'd2) w_need = 32'd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= 7'd50;
            r_cool <= 32'd5000;
            r_fw   <= 9'd40;
            r_fh   <= 9'd30;
            r_thr  <= 8'd18;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fgmd_pkg::REG_SENS:   r_sens <= i_cfg_data[6:0];
                fgmd_pkg::REG_COOL:   r_cool <= i_cfg_data;
                fgmd_pkg::REG_WIDTH:  r_fw   <= i_cfg_data[8:0];
                fgmd_pkg::REG_HEIGHT: r_fh   <= i_cfg_data[8:0];
                fgmd_pkg::REG_THRESH: r_thr  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_take) begin
            r_gray <= fgmd_pkg::gray_of(i_pixel_rgb565);
            r_last <= i_last_pixel;
            r_now  <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_primed  <= 1'b0;
            r_cend    <= '0;
            r_changed <= '0;
            r_o_valid <= 1'b0;
            r_motion  <= 1'b0;
            r_ocnt    <= '0;
            r_prime_o <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (32'(r_addr) == CELLS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_addr  <= w_idx;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_last) begin
                        r_col     <= '0;
                        r_row     <= '0;
                        r_addr    <= '0;
                        r_changed <= '0;
                        r_state   <= S_ERD;
                    end else begin
                        if (r_col + PW'(1) >= w_w) begin
                            r_col <= '0;
                            if (r_row + PW'(1) < w_h) r_row <= r_row + PW'(1);
                        end else begin
                            r_col <= r_col + PW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_ERD: r_state <= S_EDIV;
                S_EDIV: r_state <= S_EWAIT;
                S_EWAIT: begin
                    if (w_div_done) begin
                        r_changed <= w_chg_n;
                        if (32'(r_addr) == CELLS - 1) begin
                            r_o_valid <= 1'b1;
                            r_state   <= S_OUT;
                            if (!r_primed) begin
                                r_primed  <= 1'b1;
                                r_motion  <= 1'b0;
                                r_ocnt    <= '0;
                                r_prime_o <= 1'b1;
                            end else begin
                                r_ocnt    <= 10'(w_chg_n);
                                r_prime_o <= 1'b0;
                                if (32'(w_chg_n) >= w_need && r_now >= r_cend) begin
                                    r_cend   <= r_now + r_cool;
                                    r_motion <= 1'b1;
                                end else begin
                                    r_motion <= 1'b0;
                                end
                            end
                        end else begin
                            r_addr  <= r_addr + AW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_motion_event  = r_motion;
    assign o_changed_cells = r_ocnt;
    assign o_priming_frame = r_prime_o;

    `FGMD_ASSERT_IMPL(a_out_state, i_clk, i_rst_n, r_o_valid |-> (r_state == S_OUT))
    `FGMD_ASSERT_NEVER(a_prime_motion, i_clk, i_rst_n, r_o_valid && r_prime_o && r_motion)
    `FGMD_ASSERT_IMPL(a_div_after_start, i_clk, i_rst_n,
        (r_state == S_EDIV) |=> (r_state == S_EWAIT))
endmodule
